### design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and helpers for the first-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int HEAP_BYTES = 262144;
	localparam int TAG_WORDS  = HEAP_BYTES / 4;
	localparam int WORD_W     = $clog2(TAG_WORDS);
	localparam int ADDR_W     = $clog2(HEAP_BYTES) + 6;
	localparam int TAG_W      = 20;
	localparam int SIZE_W     = 19;
	localparam int PAY_W      = 18;
	localparam int CHUNK_W    = 19;

	localparam int INIT_CHUNK = 1 << 12;
	localparam int FIRST_HDR  = 4;
	localparam int INIT_BREAK = 16 + INIT_CHUNK;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_FREE    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] req_size;
		logic [PAY_W-1:0]  req_addr;
	} req_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload_addr;
		logic             status;
	} result_t;

	// Tag word contents right after reset: prologue, one free chunk, epilogue.
	function automatic logic [TAG_W-1:0] init_tag(input logic [WORD_W-1:0] idx);
		logic [TAG_W-1:0] v;
		v = '0;
		if (idx == WORD_W'(1) || idx == WORD_W'(2))
			v = TAG_W'(9);
		else if (idx == WORD_W'(3) || idx == WORD_W'((INIT_BREAK - 8) / 4))
			v = TAG_W'(INIT_CHUNK);
		else if (idx == WORD_W'((INIT_BREAK - 4) / 4))
			v = TAG_W'(1);
		return v;
	endfunction

endpackage

### design/ffa_tag_ram.sv
// ----------------------------------------------------------------------------
// ffa_tag_ram
// Single-port-write, single-port-read synchronous RAM; the read is registered.
// ----------------------------------------------------------------------------
module ffa_tag_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/ffa_engine.sv
// ----------------------------------------------------------------------------
// ffa_engine
// Sequencer for the reset-time clear, allocate, free, coalesce and heap growth over the tag RAM.
// ----------------------------------------------------------------------------
module ffa_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffa_pkg::req_t                 req,
	input  logic [ffa_pkg::CHUNK_W-1:0]   chunk,
	output logic                          done,
	output ffa_pkg::result_t              result,
	output logic                          ram_we,
	output logic [ffa_pkg::WORD_W-1:0]    ram_waddr,
	output logic [ffa_pkg::TAG_W-1:0]     ram_wdata,
	output logic [ffa_pkg::WORD_W-1:0]    ram_raddr,
	input  logic [ffa_pkg::TAG_W-1:0]     ram_rdata
);
	import ffa_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_F0, S_F1, S_F2,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
		S_W1, S_W2,
		S_T0, S_T1, S_T2, S_T3, S_T4,
		S_G0, S_G1, S_G2, S_G3
	} state_t;

	state_t              state_q;
	logic [WORD_W-1:0]   clr_q;
	logic                oor_q;
	logic                op_free_q;
	logic                pa_q;
	logic [ADDR_W-1:0]   p_q, hdr_q, nh_q, h_q, sz_q, size_q, pfs_q, need_q, brk_q;
	logic                done_q;
	result_t             result_q;

	logic                rd_en_unused;
	logic [ADDR_W-1:0]   rd_addr, wr_addr;
	logic [TAG_W-1:0]    wr_data;
	logic                wr_en;
	logic [ADDR_W-1:0]   tag_x, tsz;
	logic [ADDR_W-1:0]   blk, rest, ext, ext_min, bytes, req_need, chunk_x;

	function automatic logic in_range(input logic [ADDR_W-1:0] a);
		return a < ADDR_W'(HEAP_BYTES);
	endfunction

	assign tag_x   = oor_q ? '0 : ADDR_W'(ram_rdata);
	assign tsz     = tag_x & ~ADDR_W'(7);
	assign blk     = need_q + ADDR_W'(8);
	assign rest    = sz_q - blk;
	assign chunk_x = ADDR_W'(chunk);
	assign ext     = (need_q > chunk_x) ? need_q : chunk_x;
	assign ext_min = (ext < ADDR_W'(8)) ? ADDR_W'(8) : ext;
	assign bytes   = (ext_min + ADDR_W'(7)) & ~ADDR_W'(7);

	always_comb begin
		req_need = ADDR_W'(req.req_size);
		if (req_need < ADDR_W'(8))
			req_need = ADDR_W'(8);
		req_need = (req_need + ADDR_W'(7)) & ~ADDR_W'(7);
	end

	// Memory access issued by each state.
	always_comb begin
		rd_addr      = '0;
		rd_en_unused = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = '0;
		unique case (state_q)
			S_F0: rd_addr = p_q - ADDR_W'(4);
			S_F1: begin
				wr_en   = 1'b1;
				wr_addr = p_q - ADDR_W'(4);
				wr_data = TAG_W'(tsz);
			end
			S_F2: begin
				wr_en   = 1'b1;
				wr_addr = p_q - ADDR_W'(8) + sz_q;
				wr_data = TAG_W'(sz_q);
			end
			S_M0: rd_addr = p_q - ADDR_W'(4);
			S_M1: rd_addr = p_q - ADDR_W'(8);
			S_M2: rd_addr = nh_q;
			S_M3: begin
				if (pa_q && !tag_x[0]) begin
					wr_en   = 1'b1;
					wr_addr = hdr_q;
					wr_data = TAG_W'(size_q + tsz);
				end else if (!pa_q) begin
					rd_addr = p_q - ADDR_W'(4) - pfs_q;
				end
			end
			S_M5: begin
				wr_en   = 1'b1;
				wr_addr = hdr_q;
				wr_data = TAG_W'(size_q + tsz);
			end
			S_M4: begin
				wr_en   = 1'b1;
				wr_addr = hdr_q + size_q - ADDR_W'(4);
				wr_data = TAG_W'(size_q);
			end
			S_W1: rd_addr = h_q;
			S_T0: begin
				wr_en = 1'b1;
				if (sz_q == blk) begin
					wr_addr = h_q;
					wr_data = TAG_W'(sz_q) | TAG_W'(1);
				end else begin
					wr_addr = h_q + sz_q - ADDR_W'(4);
					wr_data = TAG_W'(rest);
				end
			end
			S_T1: begin
				wr_en   = 1'b1;
				wr_addr = h_q + sz_q - ADDR_W'(4);
				wr_data = TAG_W'(sz_q) | TAG_W'(1);
			end
			S_T2: begin
				wr_en   = 1'b1;
				wr_addr = h_q;
				wr_data = TAG_W'(blk) | TAG_W'(1);
			end
			S_T3: begin
				wr_en   = 1'b1;
				wr_addr = h_q + blk - ADDR_W'(4);
				wr_data = TAG_W'(blk) | TAG_W'(1);
			end
			S_T4: begin
				wr_en   = 1'b1;
				wr_addr = h_q + blk;
				wr_data = TAG_W'(rest);
			end
			S_G1: begin
				wr_en   = 1'b1;
				wr_addr = brk_q - ADDR_W'(4);
				wr_data = TAG_W'(sz_q);
			end
			S_G2: begin
				wr_en   = 1'b1;
				wr_addr = brk_q + sz_q - ADDR_W'(8);
				wr_data = TAG_W'(sz_q);
			end
			S_G3: begin
				wr_en   = 1'b1;
				wr_addr = brk_q + sz_q - ADDR_W'(4);
				wr_data = TAG_W'(1);
			end
			default: rd_en_unused = 1'b1;
		endcase
	end

	// The clear sweep owns the write port until it has written the last word.
	assign ram_we    = (state_q == S_CLR) || (wr_en && in_range(wr_addr) && !rd_en_unused);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : wr_addr[WORD_W+1:2];
	assign ram_wdata = (state_q == S_CLR) ? init_tag(clr_q) : wr_data;
	assign ram_raddr = rd_addr[WORD_W+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			oor_q     <= 1'b0;
			op_free_q <= 1'b0;
			brk_q     <= ADDR_W'(INIT_BREAK);
			done_q    <= 1'b0;
		end else begin
			oor_q  <= !in_range(rd_addr);
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + WORD_W'(1);
					if (clr_q == WORD_W'(TAG_WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						p_q       <= ADDR_W'(req.req_addr);
						op_free_q <= (req.req_type == REQ_FREE);
						need_q    <= req_need;
						h_q       <= ADDR_W'(FIRST_HDR);
						if (req.req_type == REQ_FREE) begin
							state_q <= S_F0;
						end else if (req.req_size == '0) begin
							done_q   <= 1'b1;
							result_q <= '{payload_addr: '0, status: STATUS_FAIL};
						end else begin
							state_q <= S_W1;
						end
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					sz_q    <= tsz;
					state_q <= S_F2;
				end
				S_F2: state_q <= S_M0;
				S_M0: begin
					hdr_q   <= p_q - ADDR_W'(4);
					state_q <= S_M1;
				end
				S_M1: begin
					size_q  <= tsz;
					nh_q    <= hdr_q + tsz;
					state_q <= S_M2;
				end
				S_M2: begin
					pa_q    <= tag_x[0];
					pfs_q   <= tsz;
					state_q <= S_M3;
				end
				S_M3: begin
					if (pa_q && tag_x[0]) begin
						// both neighbors live: nothing to merge
						if (op_free_q) begin
							done_q   <= 1'b1;
							result_q <= '{payload_addr: '0, status: STATUS_OK};
							state_q  <= S_IDLE;
						end else begin
							h_q     <= ADDR_W'(FIRST_HDR);
							state_q <= S_W1;
						end
					end else if (pa_q) begin
						size_q  <= size_q + tsz;
						state_q <= S_M4;
					end else begin
						if (!tag_x[0])
							size_q <= size_q + tsz;
						hdr_q   <= p_q - ADDR_W'(4) - pfs_q;
						state_q <= S_M5;
					end
				end
				S_M5: begin
					size_q  <= size_q + tsz;
					state_q <= S_M4;
				end
				S_M4: begin
					if (op_free_q) begin
						done_q   <= 1'b1;
						result_q <= '{payload_addr: '0, status: STATUS_OK};
						state_q  <= S_IDLE;
					end else begin
						h_q     <= ADDR_W'(FIRST_HDR);
						state_q <= S_W1;
					end
				end
				S_W1: begin
					if (h_q + ADDR_W'(4) <= brk_q)
						state_q <= S_W2;
					else
						state_q <= S_G0;
				end
				S_W2: begin
					sz_q <= tsz;
					priority if (tsz == '0) begin
						state_q <= S_G0;
					end else if (!tag_x[0] && (tsz == blk || tsz >= need_q + ADDR_W'(16))) begin
						state_q <= S_T0;
					end else if (h_q + tsz <= h_q) begin
						state_q <= S_G0;
					end else begin
						h_q     <= h_q + tsz;
						state_q <= S_W1;
					end
				end
				S_T0: state_q <= (sz_q == blk) ? S_T1 : S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T1, S_T4: begin
					done_q   <= 1'b1;
					result_q <= '{payload_addr: PAY_W'(h_q + ADDR_W'(4)), status: STATUS_OK};
					state_q  <= S_IDLE;
				end
				S_G0: begin
					sz_q <= bytes;
					if (brk_q + bytes > ADDR_W'(HEAP_BYTES)) begin
						done_q   <= 1'b1;
						result_q <= '{payload_addr: '0, status: STATUS_FAIL};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_G1;
					end
				end
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_G3;
				S_G3: begin
					brk_q   <= brk_q + sz_q;
					p_q     <= brk_q;
					state_q <= S_M0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobed while engine still working");

	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= ADDR_W'(HEAP_BYTES))
		else $error("break beyond heap");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status == STATUS_FAIL |-> result_q.payload_addr == '0)
		else $error("failed allocate carries an address");

	a_start_act: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done_q)
		else $error("accepted item neither worked on nor answered");

endmodule

### design/first_fit_boundary_tag_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// First-fit heap allocator with boundary tags kept in a tag RAM.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------
//  request   | start, busy          | req (type, size, addr)
//  result    | done (1-cycle strobe)| result (payload_addr, status)
//  config    | cfg_we               | cfg_wdata (chunk bytes)
//
// A free holds busy until the freed block is merged with any free neighbours;
// done strobes in the cycle busy falls. An allocate walks the blocks one at a
// time through the tag RAM's single read port, writes the tags for an exact fit
// or a split, and after each heap growth restarts the walk at the first block.
// A size-zero allocate answers in the next cycle. After reset the tag RAM is
// cleared and seeded, one word a cycle, and busy stays high until the last word
// is written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ffa_pkg::req_t               req,
	output logic                        done,
	output ffa_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [ffa_pkg::CHUNK_W-1:0] cfg_wdata
);
	import ffa_pkg::*;

	logic [CHUNK_W-1:0] chunk_q;
	logic               ram_we;
	logic [WORD_W-1:0]  ram_waddr, ram_raddr;
	logic [TAG_W-1:0]   ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_W'(INIT_CHUNK);
		end else if (cfg_we) begin
			chunk_q <= cfg_wdata;
		end
	end

	ffa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.chunk     (chunk_q),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ffa_tag_ram #(
		.DEPTH (TAG_WORDS),
		.WIDTH (TAG_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
